// ===== rtl/guided_bilateral_filter_pass_assert.svh =====
// Assertion macros for the guided bilateral filter pass.
// Used by rtl/guided_bilateral_filter_pass.sv; expects clk and rst in scope.
`ifndef GUIDED_BILATERAL_FILTER_PASS_ASSERT_SVH
`define GUIDED_BILATERAL_FILTER_PASS_ASSERT_SVH

// Same-cycle implication, checked at every edge out of reset.
`define GBFP_ASSERT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) else $error(msg);

// Next-cycle implication.
`define GBFP_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`endif

// ===== rtl/gbfp_pkg.sv =====
// Package for the guided bilateral filter pass: sizes, codes and sequencer states.
// No dependencies; used by rtl/guided_bilateral_filter_pass.sv.
`timescale 1ns / 1ps

package gbfp_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int MAX_HALF    = 4;

  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int ADDR_W      = COL_W + ROW_W;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  localparam int INT_DEPTH   = 257;
  localparam int GT_DEPTH    = 256;
  localparam int INT_AW      = $clog2(INT_DEPTH);
  localparam int GT_AW       = $clog2(GT_DEPTH);
  localparam int SP_DEPTH    = MAX_HALF + 1;
  localparam int SP_IDX_W    = $clog2(SP_DEPTH);

  // window offsets -MAX_HALF..MAX_HALF+1, signed
  localparam int OFF_W       = SP_IDX_W + 1;
  // signed neighbour coordinate
  localparam int POS_W       = ROW_W + 2;

  localparam int WSUM_W      = 16 + $clog2((2 * MAX_HALF + 1) * (2 * MAX_HALF + 1));
  localparam int PSUM_W      = WSUM_W + 8;
  localparam int DVD_W       = PSUM_W + 8;
  localparam int DCNT_W      = $clog2(DVD_W + 1);

  typedef enum logic [1:0] {
    OP_WRITE_PIXEL = 2'd0,
    OP_WRITE_TABLE = 2'd1,
    OP_COMPUTE     = 2'd2,
    OP_UNUSED      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    TS_SPATIAL   = 2'd0,
    TS_INTENSITY = 2'd1,
    TS_GUIDE     = 2'd2,
    TS_UNUSED    = 2'd3
  } tsel_t;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_HALF   = 2'd2,
    CFG_THREE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CENTER,
    ST_WALK,
    ST_NDATA,
    ST_I0,
    ST_I1,
    ST_SPR,
    ST_SPC,
    ST_G1,
    ST_G2,
    ST_GW,
    ST_ACC,
    ST_DIV_INIT,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/gbfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instanced by rtl/guided_bilateral_filter_pass.sv.
`timescale 1ns / 1ps

module gbfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/guided_bilateral_filter_pass.sv =====
// Guided bilateral filter pass: one joint bilateral filtered pixel per compute request.
// Depends on rtl/gbfp_pkg.sv, rtl/gbfp_ram.sv and rtl/guided_bilateral_filter_pass_assert.svh.
//
// A request carries one of three operations. A pixel write stores the image sample, the
// three guide samples and the Q8.8 estimate at (row, col). A table write loads one
// Q1.15 entry of the spatial, intensity or guide weight table. A compute walks the
// window of the configured half size around (row, col), clipped to the frame, and
// returns the weighted mean of the samples as Q8.8 together with its integer byte;
// the mean is also written back as that pixel's new estimate. All multiplies go
// through one 17x16 multiplier under a small sequencer, so the block takes no request
// while a compute runs. A compute fetches the centre, steps over each window position
// outside the frame, and for each neighbour inside the frame does an image fetch, two
// intensity reads, interpolation, two spatial and up to three guide multiplies and an
// accumulate; then it runs the bit-serial division and hands off the result. The
// default window is 5x5. The division is skipped when the weight sum is zero and then
// the result is zero. Results wait in an output register, so writes keep flowing while
// a result is not yet taken; a new compute finishes only once that register is free. A
// compute outside the configured image returns nothing. Stores come up undefined and
// are not cleared after reset.
`timescale 1ns / 1ps

module guided_bilateral_filter_pass (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [5:0]  col,
  input  logic [5:0]  row,
  input  logic [7:0]  orig_pixel,
  input  logic [7:0]  guide_0,
  input  logic [7:0]  guide_1,
  input  logic [7:0]  guide_2,
  input  logic [15:0] estimate_in,
  input  logic [1:0]  table_select,
  input  logic [8:0]  table_index,
  input  logic [15:0] table_value,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] filtered_estimate,
  output logic [7:0]  filtered_byte,
  // configuration write port
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  import gbfp_pkg::*;

  // Q1.15 product, truncated, saturated to 16 bits
  function automatic logic [15:0] qsat(input logic [32:0] p);
    logic [15:0] r;
    r = (p[32] | p[31]) ? 16'hFFFF : p[30:15];
    return r;
  endfunction

  function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = (a > b) ? (a - b) : (b - a);
    return r;
  endfunction

  // ---------------- configuration ----------------
  logic [6:0] image_width;
  logic [6:0] image_height;
  logic [2:0] half_window;
  logic       three_channel_guide;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width         <= 7'(MAX_WIDTH);
      image_height        <= 7'(MAX_HEIGHT);
      half_window         <= 3'd2;
      three_channel_guide <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WIDTH: begin
          if (cfg_data == 7'd0) begin
            image_width <= 7'd1;
          end else if (int'(cfg_data) > MAX_WIDTH) begin
            image_width <= 7'(MAX_WIDTH);
          end else begin
            image_width <= cfg_data;
          end
        end
        CFG_HEIGHT: begin
          if (cfg_data == 7'd0) begin
            image_height <= 7'd1;
          end else if (int'(cfg_data) > MAX_HEIGHT) begin
            image_height <= 7'(MAX_HEIGHT);
          end else begin
            image_height <= cfg_data;
          end
        end
        CFG_HALF: begin
          if (int'(cfg_data[2:0]) > MAX_HALF) begin
            half_window <= 3'(MAX_HALF);
          end else begin
            half_window <= cfg_data[2:0];
          end
        end
        CFG_THREE: begin
          three_channel_guide <= cfg_data[0];
        end
        default: ;
      endcase
    end
  end

  // ---------------- sequencer state ----------------
  state_t state, state_next;

  logic [ROW_W-1:0]  crow;
  logic [COL_W-1:0]  ccol;
  logic [23:0]       cguide;
  logic [15:0]       cest;
  logic signed [OFF_W-1:0] dr;
  logic signed [OFF_W-1:0] dc;
  logic              walk_end;
  logic [SP_IDX_W-1:0] adr;
  logic [SP_IDX_W-1:0] adc;
  logic [7:0]        v;
  logic [7:0]        e_idx;
  logic [7:0]        f_frac;
  logic [7:0]        gdiff1;
  logic [7:0]        gdiff2;
  logic [15:0]       gt0;
  logic [15:0]       gt1;
  logic [15:0]       gt2;
  logic [24:0]       interp_lo;
  logic [15:0]       w;
  logic [15:0]       g;
  logic [WSUM_W-1:0] wsum;
  logic [PSUM_W-1:0] psum;
  logic [DVD_W-1:0]  dvd;
  logic [WSUM_W:0]   rem;
  logic [15:0]       quo;
  logic              quo_sat;
  logic [DCNT_W-1:0] div_cnt;

  logic [15:0] spatial [SP_DEPTH];

  logic accept;
  logic out_load;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  // ---------------- window walk ----------------
  logic signed [OFF_W-1:0] h_s;
  logic signed [POS_W-1:0] nr, nc;
  logic                    in_frame;
  logic                    walk_last;
  logic [ADDR_W-1:0]       nb_addr;
  logic [ADDR_W-1:0]       ctr_addr;
  logic [ADDR_W-1:0]       req_addr;

  assign h_s = signed'({1'b0, half_window});
  assign nr  = signed'({2'b00, crow}) + POS_W'(dr);
  assign nc  = signed'({2'b00, ccol}) + POS_W'(dc);
  assign in_frame = !nr[POS_W-1] && !nc[POS_W-1]
                 && (nr < signed'({1'b0, image_height}))
                 && (nc < signed'({1'b0, image_width}));
  assign walk_last = (dr == h_s) && (dc == h_s);
  assign nb_addr   = {nr[ROW_W-1:0], nc[COL_W-1:0]};
  assign ctr_addr  = {crow, ccol};
  assign req_addr  = {row[ROW_W-1:0], col[COL_W-1:0]};

  // ---------------- stores ----------------
  logic              pix_we;
  logic              int_we;
  logic              gt_we;
  logic              est_we;
  logic [ADDR_W-1:0] est_waddr;
  logic [15:0]       est_wdata;
  logic [ADDR_W-1:0] img_raddr;
  logic [INT_AW-1:0] int_raddr;
  logic [GT_AW-1:0]  gt_raddr;
  logic [7:0]        orig_rdata;
  logic [23:0]       guide_rdata;
  logic [15:0]       est_rdata;
  logic [15:0]       int_rdata;
  logic [15:0]       gt_rdata;
  logic [15:0]       result;

  assign result = quo_sat ? 16'hFFFF : quo;

  assign pix_we = accept && (operation == OP_WRITE_PIXEL)
               && (int'(col) < MAX_WIDTH) && (int'(row) < MAX_HEIGHT);
  assign int_we = accept && (operation == OP_WRITE_TABLE) && (table_select == TS_INTENSITY)
               && (int'(table_index) < INT_DEPTH);
  assign gt_we  = accept && (operation == OP_WRITE_TABLE) && (table_select == TS_GUIDE)
               && (int'(table_index) < GT_DEPTH);
  assign est_we    = pix_we || out_load;
  assign est_waddr = out_load ? ctr_addr : req_addr;
  assign est_wdata = out_load ? result : estimate_in;

  // centre fetch while idle, neighbours while walking
  assign img_raddr = (state == ST_IDLE) ? req_addr : nb_addr;

  logic [15:0] d_dist;
  logic [15:0] vq;
  assign vq     = {orig_rdata, 8'h00};
  assign d_dist = (vq > cest) ? (vq - cest) : (cest - vq);

  always_comb begin
    int_raddr = INT_AW'({1'b0, e_idx}) + INT_AW'(1);
    gt_raddr  = gdiff2;
    if (state == ST_NDATA) begin
      int_raddr = INT_AW'(d_dist[15:8]);
      gt_raddr  = absdiff8(guide_rdata[7:0], cguide[7:0]);
    end else if (state == ST_I0) begin
      gt_raddr  = gdiff1;
    end
  end

  gbfp_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_orig_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (req_addr),
    .wdata (orig_pixel),
    .raddr (img_raddr),
    .rdata (orig_rdata)
  );

  gbfp_ram #(.WIDTH(24), .DEPTH(STORE_DEPTH)) u_guide_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (req_addr),
    .wdata ({guide_2, guide_1, guide_0}),
    .raddr (img_raddr),
    .rdata (guide_rdata)
  );

  gbfp_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_est_ram (
    .clk   (clk),
    .we    (est_we),
    .waddr (est_waddr),
    .wdata (est_wdata),
    .raddr (req_addr),
    .rdata (est_rdata)
  );

  gbfp_ram #(.WIDTH(16), .DEPTH(INT_DEPTH)) u_int_ram (
    .clk   (clk),
    .we    (int_we),
    .waddr (table_index[INT_AW-1:0]),
    .wdata (table_value),
    .raddr (int_raddr),
    .rdata (int_rdata)
  );

  gbfp_ram #(.WIDTH(16), .DEPTH(GT_DEPTH)) u_gt_ram (
    .clk   (clk),
    .we    (gt_we),
    .waddr (table_index[GT_AW-1:0]),
    .wdata (table_value),
    .raddr (gt_raddr),
    .rdata (gt_rdata)
  );

  // spatial weights are few: kept in flops, read at one index per cycle
  always_ff @(posedge clk) begin
    if (accept && (operation == OP_WRITE_TABLE) && (table_select == TS_SPATIAL)
        && (int'(table_index) < SP_DEPTH)) begin
      spatial[table_index[SP_IDX_W-1:0]] <= table_value;
    end
  end

  // ---------------- shared multiplier ----------------
  logic [16:0] mul_a;
  logic [15:0] mul_b;
  logic [32:0] mul_p;
  logic [15:0] mul_q;

  always_comb begin
    mul_a = {1'b0, w};
    mul_b = g;
    case (state)
      ST_I0:  begin mul_a = 17'(9'd256 - {1'b0, f_frac}); mul_b = int_rdata; end
      ST_I1:  begin mul_a = 17'(f_frac);                  mul_b = int_rdata; end
      ST_SPR: begin mul_a = {1'b0, w};                    mul_b = spatial[adr]; end
      ST_SPC: begin mul_a = {1'b0, w};                    mul_b = spatial[adc]; end
      ST_G1:  begin mul_a = {1'b0, gt0};                  mul_b = gt1; end
      ST_G2:  begin mul_a = {1'b0, g};                    mul_b = gt2; end
      ST_ACC: begin mul_a = {1'b0, w};                    mul_b = 16'(v); end
      default: ;
    endcase
  end

  assign mul_p = 33'(mul_a * mul_b);
  assign mul_q = qsat(mul_p);

  logic [24:0] interp_sum;
  assign interp_sum = interp_lo + mul_p[24:0];

  // ---------------- divider step ----------------
  logic [WSUM_W:0] rem_sh;
  logic            rem_ge;
  assign rem_sh = {rem[WSUM_W-1:0], dvd[DVD_W-1]};
  assign rem_ge = rem_sh >= {1'b0, wsum};

  // ---------------- state register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (operation == OP_COMPUTE)
            && ({1'b0, col} < image_width) && ({1'b0, row} < image_height)) begin
          state_next = ST_CENTER;
        end
      end
      ST_CENTER:   state_next = ST_WALK;
      ST_WALK: begin
        if (in_frame) begin
          state_next = ST_NDATA;
        end else if (walk_last) begin
          state_next = ST_DIV_INIT;
        end
      end
      ST_NDATA:    state_next = ST_I0;
      ST_I0:       state_next = ST_I1;
      ST_I1:       state_next = ST_SPR;
      ST_SPR:      state_next = ST_SPC;
      ST_SPC:      state_next = ST_G1;
      ST_G1:       state_next = ST_G2;
      ST_G2:       state_next = ST_GW;
      ST_GW:       state_next = ST_ACC;
      ST_ACC:      state_next = walk_end ? ST_DIV_INIT : ST_WALK;
      ST_DIV_INIT: state_next = (wsum == '0) ? ST_DONE : ST_DIV;
      ST_DIV: begin
        if (div_cnt == DCNT_W'(DVD_W - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        crow <= row[ROW_W-1:0];
        ccol <= col[COL_W-1:0];
      end
      ST_CENTER: begin
        cguide   <= guide_rdata;
        cest     <= est_rdata;
        dr       <= -h_s;
        dc       <= -h_s;
        walk_end <= 1'b0;
        wsum     <= '0;
        psum     <= '0;
      end
      ST_WALK: begin
        adr      <= dr[OFF_W-1] ? SP_IDX_W'(-dr) : SP_IDX_W'(dr);
        adc      <= dc[OFF_W-1] ? SP_IDX_W'(-dc) : SP_IDX_W'(dc);
        walk_end <= walk_last;
        if (dc == h_s) begin
          dc <= -h_s;
          dr <= dr + OFF_W'(1);
        end else begin
          dc <= dc + OFF_W'(1);
        end
      end
      ST_NDATA: begin
        v      <= orig_rdata;
        e_idx  <= d_dist[15:8];
        f_frac <= d_dist[7:0];
        gdiff1 <= absdiff8(guide_rdata[15:8], cguide[15:8]);
        gdiff2 <= absdiff8(guide_rdata[23:16], cguide[23:16]);
      end
      ST_I0: begin
        gt0       <= gt_rdata;
        interp_lo <= mul_p[24:0];
      end
      ST_I1: begin
        gt1 <= gt_rdata;
        w   <= interp_sum[23:8];
      end
      ST_SPR: begin
        gt2 <= gt_rdata;
        w   <= mul_q;
      end
      ST_SPC: w <= mul_q;
      ST_G1:  g <= three_channel_guide ? mul_q : gt0;
      ST_G2: begin
        if (three_channel_guide) begin
          g <= mul_q;
        end
      end
      ST_GW:  w <= mul_q;
      ST_ACC: begin
        wsum <= wsum + WSUM_W'(w);
        psum <= psum + PSUM_W'(mul_p[23:0]);
      end
      ST_DIV_INIT: begin
        dvd     <= {psum, 8'h00};
        rem     <= '0;
        quo     <= '0;
        quo_sat <= 1'b0;
        div_cnt <= '0;
      end
      ST_DIV: begin
        dvd     <= {dvd[DVD_W-2:0], 1'b0};
        rem     <= rem_ge ? (rem_sh - {1'b0, wsum}) : rem_sh;
        quo     <= {quo[14:0], rem_ge};
        quo_sat <= quo_sat | quo[15];
        div_cnt <= div_cnt + DCNT_W'(1);
      end
      default: ;
    endcase
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filtered_estimate <= result;
      filtered_byte     <= result[15:8];
    end
  end

  // ---------------- assertions ----------------
  `include "guided_bilateral_filter_pass_assert.svh"

  `GBFP_ASSERT(a_div_nonzero, state == ST_DIV, wsum != '0, "division by a zero weight sum")
  `GBFP_ASSERT(a_div_bound, state == ST_DIV, div_cnt < DCNT_W'(DVD_W), "divider overran")
  `GBFP_ASSERT(a_walk_rows, state == ST_WALK, (dr >= -h_s) && (dr <= h_s), "row offset left window")
  `GBFP_ASSERT_NEXT(a_result_loaded, out_load, out_valid && (state == ST_IDLE), "result not presented")

endmodule
